### rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Field widths, register codes, item modes and cell control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  // pattern store depth and derived widths
  localparam int PAT_MAX = 64;
  localparam int PIDX_W  = $clog2(PAT_MAX);
  localparam int LEN_W   = $clog2(PAT_MAX + 1);

  // fixed field widths
  localparam int MODE_W     = 2;
  localparam int PINDEX_W   = 6;
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 32;
  localparam int MATCH_W    = 16;
  localparam int LEN_REG_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE_WANTED = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  // controls common to every cell
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic              rot;
    logic [BYTE_W-1:0] load_byte;
    logic              load_care;
  } cell_ctl_t;

  // controls decoded per cell
  typedef struct packed {
    logic load;
    logic in_use;
    logic head;
  } cell_sel_t;

endpackage

`default_nettype wire

### rtl/mbps_in_if.sv
// ----------------------------------------------------------------------------
// mbps_in_if: input request channel
// Valid/ready handshake with one load, scan or start request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_in_if;
  import mbps_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PINDEX_W-1:0] pattern_index;
  logic [BYTE_W-1:0]   byte_value;
  logic                care_bit;
  logic                last_in_region;

  modport source (
    output valid, mode, pattern_index, byte_value, care_bit, last_in_region,
    input  ready
  );

  modport sink (
    input  valid, mode, pattern_index, byte_value, care_bit, last_in_region,
    output ready
  );
endinterface

`default_nettype wire

### rtl/mbps_out_if.sv
// ----------------------------------------------------------------------------
// mbps_out_if: result request channel
// Valid/ready handshake carrying found and the match offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_out_if;
  import mbps_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] match_offset;

  modport source (
    output valid, found, match_offset,
    input  ready
  );

  modport sink (
    input  valid, found, match_offset,
    output ready
  );
endinterface

`default_nettype wire

### rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell: one position of the scan row
// Holds one window byte and one pattern byte with its care bit, compares them.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell (
  input  wire                       clk,
  input  wire mbps_pkg::cell_ctl_t  ctl,
  input  wire mbps_pkg::cell_sel_t  sel,
  input  wire [mbps_pkg::BYTE_W-1:0] win_in,
  input  wire [mbps_pkg::BYTE_W-1:0] pat_in,
  input  wire                       care_in,
  output logic [mbps_pkg::BYTE_W-1:0] win_out,
  output logic [mbps_pkg::BYTE_W-1:0] pat_out,
  output logic                      care_out,
  output logic                      hit
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] pat_r;
  logic              care_r;

  // window byte moves one cell per scan
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= win_in;
    end
  end

  // pattern byte: direct load, or one step of ring rotation
  always_ff @(posedge clk) begin
    if (sel.load) begin
      pat_r  <= ctl.load_byte;
      care_r <= ctl.load_care;
    end else if (ctl.rot) begin
      pat_r  <= pat_in;
      care_r <= care_in;
    end
  end

  assign win_out  = win_r;
  assign pat_out  = pat_r;
  assign care_out = care_r;

  // first pattern byte (head) is always compared
  assign hit = !sel.in_use || !(sel.head || care_r) || (win_r == pat_r);

endmodule

`default_nettype wire

### rtl/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan: masked byte pattern scanner
// Streams region bytes through a row of compare cells and reports the
// offset of the wanted match, or not found at the region end.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  in_req    in   valid/ready         mode, pattern_index, byte_value,
//                                     care_bit, last_in_region
//  out_req   out  valid/ready         found, match_offset
//  cfg_*     in   cfg_we (no stall)   cfg_index, cfg_wdata
//
//  One request per cycle sustained when nothing stalls (see below). A scan
//  request gives its result through the compare stage, then the output register.
//  After a pattern_length write the pattern ring rotates one cell per cycle
//  until aligned, with in_req.ready low while it rotates.
//  Reset (rst_n, synchronous) clears control state; pattern bytes are
//  undefined until loaded. A stalled result holds the compare stage, which
//  holds in_req.ready low; a new request is taken while a result waits if
//  the pending request needs no output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan (
  input  wire                           clk,
  input  wire                           rst_n,
  mbps_in_if.sink                       in_req,
  mbps_out_if.source                    out_req,
  input  wire                           cfg_we,
  input  wire [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbps_pkg::*;

  // configuration registers
  logic [LEN_REG_W-1:0] len_r;
  logic [MATCH_W-1:0]   occ_r;

  // pattern ring alignment: cell c holds pattern byte (align_r - c) mod PAT_MAX
  logic [PIDX_W-1:0] align_r, align_nxt;
  logic [PIDX_W-1:0] target;
  logic              aligned;
  logic [LEN_W-1:0]  eff_len;

  // front stage: window shift, byte count
  logic              accept;
  logic              len_write;
  mode_t             in_mode;
  logic              is_load, is_scan, is_start;
  logic [OFF_W-1:0]  bytes_r, bytes_nxt;

  // compare stage: request held for the match decision
  logic s1_valid_r, s1_valid_nxt;
  logic s1_scan_r, s1_start_r, s1_last_r;
  logic s1_fire;

  // match bookkeeping
  logic [MATCH_W-1:0] matches_r, matches_nxt;
  logic               done_r, done_nxt;
  logic               all_hit, matched, want, res_need;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [OFF_W-1:0] out_offset_r;
  logic             out_free;

  // load address into the ring
  int                ld_diff;
  logic [PIDX_W-1:0] ld_addr;
  logic              ld_we;

  // cell row
  cell_ctl_t         ctl;
  logic [BYTE_W-1:0] win_q  [PAT_MAX];
  logic [BYTE_W-1:0] pat_q  [PAT_MAX];
  logic              care_q [PAT_MAX];
  logic [PAT_MAX-1:0] hits;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_REG_W'(1);
      occ_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH:    len_r <= cfg_wdata[LEN_REG_W-1:0];
        CFG_OCCURRENCE_WANTED: occ_r <= cfg_wdata[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, too large clamps to the store depth
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(len_r) > PAT_MAX) begin
      eff_len = LEN_W'(PAT_MAX);
    end else begin
      eff_len = LEN_W'(len_r);
    end
  end

  assign target  = PIDX_W'(eff_len - LEN_W'(1));
  assign aligned = (align_r == target);

  // rotate upward one cell per cycle until the ring matches the length
  always_comb begin
    if (aligned) begin
      align_nxt = align_r;
    end else if (align_r == PIDX_W'(PAT_MAX - 1)) begin
      align_nxt = '0;
    end else begin
      align_nxt = align_r + PIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= '0;
    end else begin
      align_r <= align_nxt;
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_mode   = mode_t'(in_req.mode);
  assign len_write = cfg_we && (cfg_index == CFG_PATTERN_LENGTH);
  assign out_free  = !out_valid_r || out_req.ready;
  assign s1_fire   = s1_valid_r && (!res_need || out_free);
  assign in_req.ready = aligned && !len_write && (!s1_valid_r || s1_fire);
  assign accept    = in_req.valid && in_req.ready;

  always_comb begin
    is_load  = 1'b0;
    is_scan  = 1'b0;
    is_start = 1'b0;
    unique case (in_mode)
      MODE_LOAD:  is_load  = 1'b1;
      MODE_SCAN:  is_scan  = 1'b1;
      MODE_START: is_start = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- front stage
  always_comb begin
    ld_diff = int'(align_r) - int'(in_req.pattern_index);
    if (ld_diff < 0) begin
      ld_diff = ld_diff + PAT_MAX;
    end
  end

  assign ld_addr = PIDX_W'(ld_diff);
  assign ld_we   = accept && is_load && (int'(in_req.pattern_index) < PAT_MAX);

  always_comb begin
    bytes_nxt = bytes_r;
    if (accept && is_start) begin
      bytes_nxt = '0;
    end else if (accept && is_scan && (bytes_r != '1)) begin
      bytes_nxt = bytes_r + OFF_W'(1);
    end
  end

  // scans after the region is done still shift; nothing reads the
  // window again before the next start clears it
  assign ctl.shift     = accept && is_scan;
  assign ctl.clear     = accept && is_start;
  assign ctl.rot       = !aligned;
  assign ctl.load_byte = in_req.byte_value;
  assign ctl.load_care = in_req.care_bit;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = is_scan || is_start;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      bytes_r    <= bytes_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_scan_r  <= is_scan;
      s1_start_r <= is_start;
      s1_last_r  <= in_req.last_in_region;
    end
  end

  // ---------------------------------------------------------------- cell row
  for (genvar c = 0; c < PAT_MAX; c++) begin : g_cell
    cell_sel_t         sel;
    logic [BYTE_W-1:0] win_in;
    logic [BYTE_W-1:0] pat_in;
    logic              care_in;

    assign sel.load   = ld_we && (ld_addr == PIDX_W'(c));
    assign sel.in_use = (LEN_W'(c) < eff_len);
    assign sel.head   = (LEN_W'(c) == (eff_len - LEN_W'(1)));

    if (c == 0) begin : g_first
      assign win_in  = in_req.byte_value;
      assign pat_in  = pat_q[PAT_MAX-1];
      assign care_in = care_q[PAT_MAX-1];
    end else begin : g_rest
      assign win_in  = win_q[c-1];
      assign pat_in  = pat_q[c-1];
      assign care_in = care_q[c-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel      (sel),
      .win_in   (win_in),
      .pat_in   (pat_in),
      .care_in  (care_in),
      .win_out  (win_q[c]),
      .pat_out  (pat_q[c]),
      .care_out (care_q[c]),
      .hit      (hits[c])
    );
  end

  // ---------------------------------------------------------------- compare stage
  assign all_hit  = &hits;
  assign matched  = s1_scan_r && !done_r && all_hit &&
                    (bytes_r >= OFF_W'(eff_len));
  assign want     = matched && (matches_r == occ_r);
  assign res_need = s1_scan_r && !done_r && (want || s1_last_r);

  always_comb begin
    matches_nxt = matches_r;
    done_nxt    = done_r;
    if (s1_fire) begin
      if (s1_start_r) begin
        matches_nxt = '0;
        done_nxt    = 1'b0;
      end else if (s1_scan_r && !done_r) begin
        if (want) begin
          done_nxt = 1'b1;
        end else begin
          if (matched && (matches_r != '1)) begin
            matches_nxt = matches_r + MATCH_W'(1);
          end
          if (s1_last_r) begin
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_r <= '0;
      done_r    <= 1'b0;
    end else begin
      matches_r <= matches_nxt;
      done_r    <= done_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && res_need) begin
      out_valid_nxt = 1'b1;
    end else if (out_req.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_need) begin
      out_found_r  <= want;
      out_offset_r <= want ? (bytes_r - OFF_W'(eff_len)) : '0;
    end
  end

  assign out_req.valid        = out_valid_r;
  assign out_req.found        = out_found_r;
  assign out_req.match_offset = out_offset_r;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_no_req_while_rotating: assert property (
    @(posedge clk) disable iff (!rst_n) !aligned |-> !in_req.ready
  ) else $error("request taken while pattern ring is rotating");

  a_result_closes_region: assert property (
    @(posedge clk) disable iff (!rst_n) (s1_fire && res_need) |=> done_r
  ) else $error("result given but region not marked done");

  a_done_sticks: assert property (
    @(posedge clk) disable iff (!rst_n)
      (done_r && !(s1_fire && s1_start_r)) |=> done_r
  ) else $error("region done cleared without a start");

  a_not_found_zero_offset: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_found_r) |-> (out_offset_r == '0)
  ) else $error("not found result with nonzero offset");
`endif

endmodule

`default_nettype wire

### sim/tb_masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scan: self-checking bench for the masked byte scanner
// Loads masked patterns, streams regions with planted and accidental matches,
// and checks every found / not-found report against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;
  import mbps_pkg::*;

  // register indexes the block decodes as no-ops
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD3 = 2'd3;
  // mode code the block ignores
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // compare stage + output register, with margin
  localparam int SETTLE_CYCLES = 4;
  // requests that change scanner state before the random part stops
  localparam int ITEM_TARGET = 1300;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [PINDEX_W-1:0] idx;
    logic [BYTE_W-1:0]   val;
    logic                care;
    logic                last;
  } scan_req_t;

  typedef struct {
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mbps_in_if  in_bus ();
  mbps_out_if out_bus ();

  masked_byte_pattern_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_bus),
    .out_req   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the pattern, the window and the counters.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]    pat_byte [PAT_MAX];
  logic                 pat_care [PAT_MAX];
  logic [BYTE_W-1:0]    win [PAT_MAX];     // win[0] is the newest region byte
  bit   [OFF_W-1:0]     seen_cnt;
  bit   [MATCH_W-1:0]   match_cnt;
  bit                   region_closed;
  bit   [LEN_REG_W-1:0] len_reg;
  bit   [MATCH_W-1:0]   occ_reg;

  scan_report_t awaited_reports[$];  // reports predicted, not yet seen
  int  errors;
  int  sent;                          // requests that changed scanner state
  bit  quiet;                         // 1: no idling on either side

  // --------------------------------------------------------------------------
  // Clock, limit, result-side stalls
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous time ceiling, far above the slowest legal run
  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // result ready drops at random, about 8 percent of the time, unless a quiet stretch is on
  always @(posedge clk) begin
    out_bus.ready <= quiet || ($urandom_range(99) >= 8);
  end

  // --------------------------------------------------------------------------
  // Report checker: every accepted result is matched against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    scan_report_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected report found=%0b offset=%0d",
                   out_bus.found, out_bus.match_offset);
      end else begin
        want = awaited_reports.pop_front();
        if (out_bus.found !== want.found || out_bus.match_offset !== want.offset) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                     want.found, want.offset, out_bus.found, out_bus.match_offset);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_region();
    for (int j = 0; j < PAT_MAX; j++) win[j] = '0;
    seen_cnt      = '0;
    match_cnt     = '0;
    region_closed = 1'b0;
  endfunction

  function automatic int eff_length(input int lenv);
    // zero behaves as one, anything beyond the store as the full store
    if (lenv == 0) return 1;
    if (lenv > PAT_MAX) return PAT_MAX;
    return lenv;
  endfunction

  // Applies one accepted request; queues the report it causes, if any.
  function automatic void advance_scanner(input scan_req_t r);
    int           len;
    bit           hit;
    scan_report_t rep;
    case (r.mode)
      MODE_LOAD: begin
        if (r.idx < PAT_MAX) begin
          pat_byte[r.idx] = r.val;
          pat_care[r.idx] = r.care;
        end
        sent++;
      end
      MODE_START: begin
        clear_region();
        sent++;
      end
      MODE_SCAN: begin
        if (!region_closed) begin
          sent++;
          for (int j = PAT_MAX - 1; j > 0; j--) win[j] = win[j-1];
          win[0] = r.val;
          if (seen_cnt != '1) seen_cnt++;
          len = eff_length(len_reg);
          // no match until the window holds a full pattern's worth of bytes
          hit = (seen_cnt >= len);
          for (int j = 0; j < len; j++)
            if ((j == 0 || pat_care[j]) && win[len-1-j] != pat_byte[j]) hit = 1'b0;
          if (hit && match_cnt == occ_reg) begin
            region_closed = 1'b1;
            rep.found  = 1'b1;
            rep.offset = seen_cnt - len;
            awaited_reports.push_back(rep);
          end else begin
            if (hit && match_cnt != '1) match_cnt++;
            if (r.last) begin
              // region ran out without the wanted match
              region_closed = 1'b1;
              rep.found  = 1'b0;
              rep.offset = '0;
              awaited_reports.push_back(rep);
            end
          end
        end
      end
      default: ;  // unused mode: dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request builders: fields a mode ignores are still randomized
  // --------------------------------------------------------------------------
  function automatic scan_req_t load_req(input int idx, input logic [BYTE_W-1:0] val,
                                         input logic care);
    scan_req_t r;
    r.mode = MODE_LOAD;
    r.idx  = PINDEX_W'(idx);
    r.val  = val;
    r.care = care;
    r.last = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic scan_req_t scan_req(input logic [BYTE_W-1:0] val, input logic last);
    scan_req_t r;
    r.mode = MODE_SCAN;
    r.idx  = PINDEX_W'($urandom_range(PAT_MAX - 1));
    r.val  = val;
    r.care = 1'($urandom_range(1));
    r.last = last;
    return r;
  endfunction

  function automatic scan_req_t start_req();
    scan_req_t r;
    r.mode = MODE_START;
    r.idx  = PINDEX_W'($urandom_range(PAT_MAX - 1));
    r.val  = BYTE_W'($urandom_range(255));
    r.care = 1'($urandom_range(1));
    r.last = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic scan_req_t junk_req();
    scan_req_t r;
    r.mode = MODE_UNUSED;
    r.idx  = PINDEX_W'($urandom_range(PAT_MAX - 1));
    r.val  = BYTE_W'($urandom_range(255));
    r.care = 1'($urandom_range(1));
    r.last = 1'($urandom_range(1));
    return r;
  endfunction

  // half the region bytes come from the active pattern so matches show up
  function automatic logic [BYTE_W-1:0] pick_byte(input int eff);
    if ($urandom_range(1)) return pat_byte[$urandom_range(eff - 1)];
    return BYTE_W'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // Driving. Every task starts and ends on a rising edge.
  // --------------------------------------------------------------------------
  // Sends one request; valid stays high on return so back-to-back requests
  // never lower and raise it in the same step.
  task automatic push_request(input scan_req_t r);
    if (!quiet && $urandom_range(99) < 8) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.mode           <= r.mode;
    in_bus.pattern_index  <= r.idx;
    in_bus.byte_value     <= r.val;
    in_bus.care_bit       <= r.care;
    in_bus.last_in_region <= r.last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    advance_scanner(r);
  endtask

  // stop sending and wait for every predicted report
  task automatic hold_until_reported();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // idle point: nothing awaited and no request left in the pipe
  task automatic settle();
    hold_until_reported();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_PATTERN_LENGTH:    len_reg = data[LEN_REG_W-1:0];
      CFG_OCCURRENCE_WANTED: occ_reg = data[MATCH_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  // Length goes last: its write starts a ring realignment, and no other
  // write may land while that is running.
  task automatic configure(input logic [CFG_DATA_W-1:0] lenw, input logic [CFG_DATA_W-1:0] occw);
    set_reg(CFG_OCCURRENCE_WANTED, occw);
    set_reg(CFG_PATTERN_LENGTH, lenw);
  endtask

  // streams one copy of the pattern; wildcard positions get random bytes
  task automatic plant_match(input int eff, input bit end_region);
    logic [BYTE_W-1:0] b;
    for (int j = 0; j < eff; j++) begin
      b = (j == 0 || pat_care[j]) ? pat_byte[j] : BYTE_W'($urandom_range(255));
      push_request(scan_req(b, end_region && j == eff - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every store entry is written before any scan can read it. Entry 0 gets
  // a wildcard flag that must be overruled; entry 1 and the top entry get the
  // byte extremes.
  task automatic test_load_pattern();
    logic [BYTE_W-1:0] v;
    logic              c;
    for (int j = 0; j < PAT_MAX; j++) begin
      v = BYTE_W'($urandom_range(255));
      c = 1'($urandom_range(1));
      if (j == 0) c = 1'b0;
      if (j == 1) v = 8'h00;
      if (j == PAT_MAX - 1) begin
        v = 8'hFF;
        c = 1'b1;
      end
      push_request(load_req(j, v, c));
    end
  endtask

  // Reset config (length 1, first match), no start request since reset.
  task automatic test_defaults_after_reset();
    logic [BYTE_W-1:0] b0;
    b0 = pat_byte[0];
    push_request(scan_req(b0 ^ 8'h80, 1'b0));
    push_request(scan_req(~b0, 1'b0));
    push_request(scan_req(b0, 1'b0));         // found at offset 2
    push_request(scan_req(b0, 1'b1));         // region already done: dropped
    push_request(junk_req());
    push_request(start_req());
    push_request(scan_req(~b0, 1'b0));
    push_request(scan_req(b0 ^ 8'h01, 1'b1)); // not found
    push_request(start_req());
    push_request(scan_req(b0, 1'b1));         // match on the final byte
    push_request(start_req());
    push_request(scan_req(~b0, 1'b0));
    push_request(scan_req(b0, 1'b0));
    // sender backs off until the report is out, then resumes mid-region
    hold_until_reported();
    push_request(scan_req(b0, 1'b1));
  endtask

  task automatic test_length_limits();
    logic [BYTE_W-1:0] b0;
    b0 = pat_byte[0];
    // length 0 with junk in the upper data bits: behaves as length 1
    configure(16'hFF80, 16'h0000);
    push_request(start_req());
    push_request(scan_req(~b0, 1'b0));
    push_request(scan_req(b0, 1'b1));
    // 127 clamps to the full store; full-width match ends the region
    configure(16'h007F, 16'h0000);
    push_request(start_req());
    push_request(scan_req(BYTE_W'($urandom_range(255)), 1'b0));
    push_request(scan_req(BYTE_W'($urandom_range(255)), 1'b0));
    plant_match(PAT_MAX, 1'b1);
    // 4-byte zero pattern, wildcards behind the head, head flagged wildcard
    push_request(load_req(0, 8'h00, 1'b0));
    for (int j = 1; j < 4; j++)
      push_request(load_req(j, BYTE_W'($urandom_range(255)), 1'b0));
    configure(16'd4, 16'h0000);
    // leading zero would match the cleared window without the fill guard
    push_request(start_req());
    push_request(scan_req(8'h00, 1'b0));
    push_request(scan_req(8'h05, 1'b0));
    push_request(scan_req(8'h05, 1'b0));
    push_request(scan_req(8'h05, 1'b1));
    // head byte is compared even with its wildcard flag set
    push_request(start_req());
    push_request(scan_req(8'h05, 1'b0));
    repeat (3) push_request(scan_req(8'h00, 1'b0));
    push_request(scan_req(8'h00, 1'b1));
  endtask

  task automatic test_occurrence_limits();
    logic [BYTE_W-1:0] b0;
    b0 = pat_byte[0];
    // top index is never reached
    configure(16'd1, 16'hFFFF);
    push_request(start_req());
    repeat (3) push_request(scan_req(b0, 1'b0));
    push_request(scan_req(b0, 1'b1));
    // third match wins, the rest of the region is dropped
    configure(16'd1, 16'd2);
    push_request(start_req());
    repeat (3) push_request(scan_req(b0, 1'b0));
    push_request(scan_req(b0, 1'b1));
  endtask

  // writes to the spare indexes must leave length and occurrence alone
  task automatic test_spare_registers();
    logic [BYTE_W-1:0] b0;
    b0 = pat_byte[0];
    set_reg(CFG_RSVD2, CFG_DATA_W'($urandom_range(16'hFFFF)));
    set_reg(CFG_RSVD3, 16'hFFFF);
    push_request(start_req());
    push_request(scan_req(b0, 1'b0));
    push_request(scan_req(b0, 1'b0));
    push_request(scan_req(b0, 1'b1));
  endtask

  // Phases of random config, each with a few regions. Most regions are well
  // formed with planted copies of the pattern; some drop the start or the
  // last flag, carry mid-region loads or unused-mode requests, or keep
  // scanning after the report.
  task automatic test_random_regions();
    int                    phase;
    int                    lenv;
    int                    eff;
    int                    rlen;
    int                    i;
    int                    r;
    bit                    broken;
    logic [CFG_DATA_W-1:0] lw;
    logic [CFG_DATA_W-1:0] ow;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 70)      lenv = $urandom_range(1, 6);
      else if (r < 85) lenv = $urandom_range(7, 20);
      else if (r < 92) lenv = $urandom_range(21, PAT_MAX);
      else             lenv = $urandom_range(1) ? 0 : $urandom_range(PAT_MAX + 1, 127);
      lw = CFG_DATA_W'(lenv);
      if ($urandom_range(4) == 0)
        lw[CFG_DATA_W-1:LEN_REG_W] = (CFG_DATA_W - LEN_REG_W)'($urandom);
      r = $urandom_range(99);
      if (r < 75)      ow = CFG_DATA_W'($urandom_range(3));
      else if (r < 92) ow = CFG_DATA_W'($urandom_range(4, 10));
      else             ow = $urandom_range(1) ? 16'hFFFF : CFG_DATA_W'($urandom_range(16'hFFFF));
      configure(lw, ow);
      quiet <= (phase >= 4 && phase < 9);
      eff = eff_length(lenv);
      if ($urandom_range(99) < 40)
        for (int j = 0; j < eff; j++)
          push_request(load_req(j, BYTE_W'($urandom_range(255)), $urandom_range(9) < 7));
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(99) < 95) push_request(start_req());
        broken = ($urandom_range(99) < 8);
        rlen = eff + $urandom_range(0, 2 * eff + 12);
        i = 0;
        while (i < rlen) begin
          r = $urandom_range(99);
          if (r < 3) begin
            push_request(junk_req());
          end else if (r < 5) begin
            push_request(load_req($urandom_range(PAT_MAX - 1), BYTE_W'($urandom_range(255)),
                                  1'($urandom_range(1))));
          end else if (r < 20 && rlen - i >= eff) begin
            plant_match(eff, !broken && i + eff == rlen);
            i += eff;
          end else begin
            push_request(scan_req(pick_byte(eff), !broken && i == rlen - 1));
            i++;
          end
        end
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 3))
            push_request(scan_req(BYTE_W'($urandom_range(255)), 1'($urandom_range(1))));
      end
      phase++;
    end
    quiet <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    in_bus.valid          = 1'b0;
    in_bus.mode           = MODE_LOAD;
    in_bus.pattern_index  = '0;
    in_bus.byte_value     = '0;
    in_bus.care_bit       = 1'b0;
    in_bus.last_in_region = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_PATTERN_LENGTH;
    cfg_wdata             = '0;
    rst_n                 = 1'b0;
    quiet                 = 1'b0;
    errors                = 0;
    sent                  = 0;
    // reset state: stores hold nothing we ever read before loading them
    for (int j = 0; j < PAT_MAX; j++) begin
      pat_byte[j] = '0;
      pat_care[j] = 1'b0;
    end
    clear_region();
    len_reg = LEN_REG_W'(1);
    occ_reg = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_pattern();
    test_defaults_after_reset();
    test_length_limits();
    test_occurrence_limits();
    test_spare_registers();
    test_random_regions();

    settle();
    errors += awaited_reports.size();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/mbps_pkg.sv
rtl/mbps_in_if.sv
rtl/mbps_out_if.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scan.sv
sim/tb_masked_byte_pattern_scan.sv
